// ===== rtl/core/ofdm_symbol_sampler_core_assert.svh =====
// Assertion macros for the OFDM symbol sampler checker
`ifndef OFDM_SYMBOL_SAMPLER_CORE_ASSERT_SVH
`define OFDM_SYMBOL_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication
`define OSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/oss_pkg.sv =====
// Package: shared types and constants of the OFDM symbol sampler
`timescale 1ns / 1ps

package oss_pkg;

	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;

	localparam logic [7:0]  SYMBOL_LENGTH_RST = 8'd80;
	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd16;

	typedef enum logic {
		CTL_TAKE,
		CTL_READ
	} ctl_state_t;

	typedef enum logic {
		MODE_IDLE,
		MODE_FRAME
	} mode_t;

	typedef struct packed {
		logic wr;
		logic win_start;
		logic win_pre;
		logic rd_issue;
	} dp_cmd_t;

	typedef struct packed {
		logic can_issue;
		logic last_issue;
	} dp_sts_t;

endpackage

// ===== rtl/core/oss_ram.sv =====
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module oss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/oss_datapath.sv =====
// Datapath: history ring, slot valid bits, window read pipeline, output stage
`timescale 1ns / 1ps

module oss_datapath #(
	parameter int FFT_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oss_pkg::dp_cmd_t   cmd,
	output oss_pkg::dp_sts_t   sts,
	input  logic signed [15:0] sample_i,
	input  logic signed [15:0] sample_q,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic               preamble_start,
	output logic               symbol_last
);

	localparam int AW    = oss_pkg::RING_AW;
	localparam int DEPTH = oss_pkg::RING_DEPTH;
	localparam int CNT_W = $clog2(FFT_LEN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FFT_LEN - 1);
	localparam logic [AW-1:0]    WIN_BACK = AW'(FFT_LEN);

	logic [AW-1:0]    ptr_q;
	logic [DEPTH-1:0] slot_valid_q;
	logic [AW-1:0]    rd_addr_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             pre_q;
	logic [31:0]      rdata;

	logic             valid_s1;
	logic             vbit_s1;
	logic             first_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic [15:0]      out_i_q;
	logic [15:0]      out_q_q;
	logic             pre_out_q;
	logic             last_out_q;
	logic             out_load;

	oss_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (ptr_q),
		.wdata ({sample_q, sample_i}),
		.re    (cmd.rd_issue),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign out_load       = valid_s1 && (!out_valid_q || !out_stall);
	assign sts.can_issue  = !valid_s1 || out_load;
	assign sts.last_issue = (rd_cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			slot_valid_q <= '0;
		end else if (cmd.wr) begin
			ptr_q               <= ptr_q + AW'(1);
			slot_valid_q[ptr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_cnt_q  <= '0;
			pre_q     <= 1'b0;
		end else if (cmd.win_start) begin
			// window ends at the slot written this cycle
			rd_addr_q <= ptr_q + AW'(1) - WIN_BACK;
			rd_cnt_q  <= '0;
			pre_q     <= cmd.win_pre;
		end else if (cmd.rd_issue) begin
			rd_addr_q <= rd_addr_q + AW'(1);
			rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.rd_issue) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			vbit_s1  <= slot_valid_q[rd_addr_q];
			first_s1 <= pre_q && (rd_cnt_q == '0);
			last_s1  <= (rd_cnt_q == CNT_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_i_q    <= vbit_s1 ? rdata[15:0] : 16'd0;
			out_q_q    <= vbit_s1 ? rdata[31:16] : 16'd0;
			pre_out_q  <= first_s1;
			last_out_q <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_i          = out_i_q;
	assign out_q          = out_q_q;
	assign preamble_start = pre_out_q;
	assign symbol_last    = last_out_q;

endmodule

// ===== rtl/core/oss_ctrl.sv =====
// Controller: frame state, symbol counters, config registers, readout sequencing
`timescale 1ns / 1ps

module oss_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [oss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [oss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             trigger,
	input  oss_pkg::dp_sts_t                 sts,
	output oss_pkg::dp_cmd_t                 cmd
);

	oss_pkg::ctl_state_t state_q, state_nxt;
	oss_pkg::mode_t      mode_q;
	logic [7:0]          sample_cnt_q;
	logic [15:0]         symbols_left_q;
	logic [7:0]          symbol_length_q;
	logic [15:0]         timeout_limit_q;

	logic                accept;
	logic [7:0]          cnt_inc;
	logic                data_hit;

	assign cnt_inc  = sample_cnt_q + 8'd1;
	assign data_hit = (mode_q == oss_pkg::MODE_FRAME) && (cnt_inc == symbol_length_q);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oss_pkg::CTL_TAKE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		in_stall      = 1'b1;
		cmd.wr        = 1'b0;
		cmd.win_start = 1'b0;
		cmd.win_pre   = trigger;
		cmd.rd_issue  = 1'b0;
		unique case (state_q)
			oss_pkg::CTL_TAKE: begin
				in_stall      = 1'b0;
				cmd.wr        = in_valid;
				cmd.win_start = in_valid && (trigger || data_hit);
				if (in_valid && (trigger || data_hit)) begin
					state_nxt = oss_pkg::CTL_READ;
				end
			end
			oss_pkg::CTL_READ: begin
				cmd.rd_issue = sts.can_issue;
				if (sts.can_issue && sts.last_issue) begin
					state_nxt = oss_pkg::CTL_TAKE;
				end
			end
			default: begin
				state_nxt = oss_pkg::CTL_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= oss_pkg::MODE_IDLE;
			sample_cnt_q   <= '0;
			symbols_left_q <= '0;
		end else if (accept) begin
			if (trigger) begin
				mode_q         <= oss_pkg::MODE_FRAME;
				sample_cnt_q   <= '0;
				symbols_left_q <= timeout_limit_q;
			end else if (mode_q == oss_pkg::MODE_FRAME) begin
				if (data_hit) begin
					sample_cnt_q <= '0;
					if (symbols_left_q == '0) begin
						mode_q <= oss_pkg::MODE_IDLE;
					end else begin
						symbols_left_q <= symbols_left_q - 16'd1;
					end
				end else begin
					sample_cnt_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_length_q <= oss_pkg::SYMBOL_LENGTH_RST;
			timeout_limit_q <= oss_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == oss_pkg::REG_SYMBOL_LENGTH) begin
				symbol_length_q <= cfg_data[7:0];
			end
			if (cfg_index == oss_pkg::REG_TIMEOUT_LIMIT) begin
				timeout_limit_q <= cfg_data[15:0];
			end
		end
	end

endmodule

// ===== rtl/core/ofdm_symbol_sampler_core.sv =====
// Top level: OFDM symbol sampler with cyclic prefix removal
//
// channel  handshake             payload
// in       in_valid / in_stall   sample_i, sample_q, trigger
// out      out_valid / out_stall out_i, out_q, preamble_start, symbol_last
// cfg      cfg_wr_en             cfg_index, cfg_data
//
// A request that opens no window is taken without stalling.
// A request that opens a window is taken, then in_stall stays high while the
// ring RAM read port reads the window of FFT_LEN slots, one slot per cycle
// unless out_stall holds the read pipeline, which keeps in_stall high longer.
// Reset clears pointer, slot valid bits and frame state and loads config defaults;
// unwritten slots read 0.
`timescale 1ns / 1ps

module ofdm_symbol_sampler_core #(
	parameter int FFT_LEN = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [oss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             sample_i,
	input  logic signed [15:0]             sample_q,
	input  logic                           trigger,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             out_i,
	output logic signed [15:0]             out_q,
	output logic                           preamble_start,
	output logic                           symbol_last
);

	oss_pkg::dp_cmd_t cmd;
	oss_pkg::dp_sts_t sts;

	oss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.trigger   (trigger),
		.sts       (sts),
		.cmd       (cmd)
	);

	oss_datapath #(
		.FFT_LEN(FFT_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_i          (out_i),
		.out_q          (out_q),
		.preamble_start (preamble_start),
		.symbol_last    (symbol_last)
	);

endmodule

// ===== rtl/core/oss_checker.sv =====
// Port-level assertion checker for the OFDM symbol sampler, with its bind
`timescale 1ns / 1ps
`include "ofdm_symbol_sampler_core_assert.svh"

module oss_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wr_en,
	input logic [oss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [oss_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic signed [15:0]             sample_i,
	input logic signed [15:0]             sample_q,
	input logic                           trigger,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [15:0]             out_i,
	input logic signed [15:0]             out_q,
	input logic                           preamble_start,
	input logic                           symbol_last
);

	`OSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_i) && $stable(out_q) && $stable(preamble_start) && $stable(symbol_last), "stalled output request changed")
	`OSS_ASSERT_NOW(a_flags_apart, out_valid, !(preamble_start && symbol_last), "preamble start and symbol last on one sample")
	`OSS_ASSERT_NEXT(a_trig_reads, in_valid && !in_stall && trigger, in_stall, "trigger request did not start window readout")

endmodule

bind ofdm_symbol_sampler_core oss_checker u_oss_checker (.*);
